/* src/mcal_pkg.sv */
// Package for the magnetometer calibration and heading block.
// Holds register codes, reset values, widths, the sideband type and the arctangent table.
// Used by magnetometer_calibrate_heading; depends on nothing.
package mcal_pkg;

  localparam logic [2:0] REG_OFFSET_X = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y = 3'd1;
  localparam logic [2:0] REG_OFFSET_Z = 3'd2;
  localparam logic [2:0] REG_ROW_X    = 3'd3;
  localparam logic [2:0] REG_ROW_Y    = 3'd4;
  localparam logic [2:0] REG_ROW_Z    = 3'd5;
  localparam logic [2:0] REG_DECL     = 3'd6;

  localparam logic [47:0] ROW_X_RESET = 48'h0000_0000_4000;
  localparam logic [47:0] ROW_Y_RESET = 48'h0000_4000_0000;
  localparam logic [47:0] ROW_Z_RESET = 48'h4000_0000_0000;

  // Offset-corrected sample, one coefficient product, and a row sum.
  localparam int DiffW = 17;
  localparam int ProdW = 33;
  localparam int SumW  = 35;
  // CORDIC datapath: a 16-bit component scaled by 2^16, grown by the CORDIC gain.
  localparam int CordW = 35;

  localparam int AtanEntries = 24;
  localparam logic [31:0] ATAN_TURN [AtanEntries] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic               bus_err;
    logic               sat;
    logic               zero;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
  } side_t;

endpackage

/* src/magnetometer_calibrate_heading.sv */
// Magnetometer hard/soft-iron calibration with a CORDIC heading, fully pipelined.
// Depends on mcal_pkg for register codes, widths, the sideband struct and the atan table.
//
// Usage: a raw X/Y/Z sample with a bus-ok flag enters on the input channel when
// in_valid_i is high and in_stall_o is low. The block subtracts the hard-iron
// offsets, applies the soft-iron matrix, rounds and clips to 16 bits, then runs a
// vectoring CORDIC for the heading and adds the declination.
// Stages in order: offset subtract, nine parallel multiplies, row sum and clip,
// CORDIC set-up, one register stage per CORDIC iteration, then the heading add
// into the output register. Throughput is one item per cycle unless the receiver
// stalls; every stage holds a valid bit.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall_o rises in the same cycle, so nothing is lost or repeated.
// Configuration writes are taken in any cycle (cfg_ready_o is always high) and
// must be made only while the pipeline is empty. Index 7 is ignored.
// Reset clears all valid bits and loads zero offsets, an identity matrix and zero
// declination. A bus-error item returns bus_error with every other field zero.
module magnetometer_calibrate_heading
  import mcal_pkg::*;
#(
  parameter int CORDIC_STAGES  = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] raw_x_i,
  input  logic signed [15:0] raw_y_i,
  input  logic signed [15:0] raw_z_i,
  input  logic               bus_ok_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] mag_x_o,
  output logic signed [15:0] mag_y_o,
  output logic signed [15:0] mag_z_o,
  output logic [15:0]        heading_o,
  output logic               bus_error_o,
  output logic               saturated_o
);

  localparam logic signed [SumW-1:0] Round = SumW'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [SumW-1:0] ClipHi = SumW'(32767);
  localparam logic signed [SumW-1:0] ClipLo = -SumW'(32768);

  // ---------------- configuration registers ----------------
  logic signed [15:0] off_x_q, off_y_q, off_z_q, decl_q;
  logic [47:0]        row_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q  <= '0;
      off_y_q  <= '0;
      off_z_q  <= '0;
      decl_q   <= '0;
      row_q[0] <= ROW_X_RESET;
      row_q[1] <= ROW_Y_RESET;
      row_q[2] <= ROW_Z_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_OFFSET_X: off_x_q  <= cfg_data_i[15:0];
        REG_OFFSET_Y: off_y_q  <= cfg_data_i[15:0];
        REG_OFFSET_Z: off_z_q  <= cfg_data_i[15:0];
        REG_ROW_X:    row_q[0] <= cfg_data_i;
        REG_ROW_Y:    row_q[1] <= cfg_data_i;
        REG_ROW_Z:    row_q[2] <= cfg_data_i;
        REG_DECL:     decl_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic advance;
  logic out_valid_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  // Valid bits: s1, s2, s3, then the CORDIC chain (index 0 is the set-up stage).
  logic                     v1_q, v2_q, v3_q;
  logic [CORDIC_STAGES:0]   cv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      cv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      cv_q        <= {cv_q[CORDIC_STAGES-1:0], v3_q};
      out_valid_q <= cv_q[CORDIC_STAGES];
    end
  end

  // ---------------- stage 1: offset subtract ----------------
  logic signed [DiffW-1:0] d_q [3];
  logic                    ok1_q, ok2_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      d_q[0] <= $signed({raw_x_i[15], raw_x_i}) - $signed({off_x_q[15], off_x_q});
      d_q[1] <= $signed({raw_y_i[15], raw_y_i}) - $signed({off_y_q[15], off_y_q});
      d_q[2] <= $signed({raw_z_i[15], raw_z_i}) - $signed({off_z_q[15], off_z_q});
      ok1_q  <= bus_ok_i;
    end
  end

  // ---------------- stage 2: nine coefficient products ----------------
  logic signed [ProdW-1:0] p_q [3][3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [15:0]      coef;
      logic signed [ProdW-1:0] coef_ext, d_ext;
      assign coef     = row_q[r][16*c +: 16];
      assign coef_ext = {{(ProdW-16){coef[15]}}, coef};
      assign d_ext    = {{(ProdW-DiffW){d_q[c][DiffW-1]}}, d_q[c]};
      always_ff @(posedge clk_i) begin
        if (advance) begin
          p_q[r][c] <= coef_ext * d_ext;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ok2_q <= ok1_q;
    end
  end

  // ---------------- stage 3: row sums, rounding, clipping ----------------
  logic signed [15:0] m_d [3];
  logic [2:0]         clip_d;
  side_t              side3_q;

  for (genvar r = 0; r < 3; r++) begin : g_sum
    logic signed [SumW-1:0] acc, shr;
    always_comb begin
      acc = $signed({{(SumW-ProdW){p_q[r][0][ProdW-1]}}, p_q[r][0]})
          + $signed({{(SumW-ProdW){p_q[r][1][ProdW-1]}}, p_q[r][1]})
          + $signed({{(SumW-ProdW){p_q[r][2][ProdW-1]}}, p_q[r][2]})
          + Round;
      shr = acc >>> COEF_FRAC_BITS;
      priority if (shr > ClipHi) begin
        m_d[r]    = 16'sh7fff;
        clip_d[r] = 1'b1;
      end else if (shr < ClipLo) begin
        m_d[r]    = -16'sh8000;
        clip_d[r] = 1'b1;
      end else begin
        m_d[r]    = shr[15:0];
        clip_d[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      side3_q.bus_err <= !ok2_q;
      side3_q.sat     <= |clip_d;
      side3_q.zero    <= (m_d[0] == '0) && (m_d[1] == '0);
      side3_q.mx      <= m_d[0];
      side3_q.my      <= m_d[1];
      side3_q.mz      <= m_d[2];
    end
  end

  // ---------------- CORDIC set-up and iterations ----------------
  logic signed [CordW-1:0] cx_q  [CORDIC_STAGES+1];
  logic signed [CordW-1:0] cy_q  [CORDIC_STAGES+1];
  logic [31:0]             ca_q  [CORDIC_STAGES+1];
  side_t                   cs_q  [CORDIC_STAGES+1];

  logic signed [CordW-1:0] x0, y0;
  assign x0 = {{(CordW-32){side3_q.mx[15]}}, side3_q.mx, 16'h0000};
  assign y0 = {{(CordW-32){side3_q.my[15]}}, side3_q.my, 16'h0000};

  // A vector in the left half-plane is turned by half a turn first.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (side3_q.mx[15]) begin
        cx_q[0] <= -x0;
        cy_q[0] <= -y0;
        ca_q[0] <= 32'h8000_0000;
      end else begin
        cx_q[0] <= x0;
        cy_q[0] <= y0;
        ca_q[0] <= 32'h0000_0000;
      end
      cs_q[0] <= side3_q;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    logic signed [CordW-1:0] xs, ys;
    assign xs = cx_q[g] >>> g;
    assign ys = cy_q[g] >>> g;
    always_ff @(posedge clk_i) begin
      if (advance) begin
        if (!cy_q[g][CordW-1]) begin
          cx_q[g+1] <= cx_q[g] + ys;
          cy_q[g+1] <= cy_q[g] - xs;
          ca_q[g+1] <= ca_q[g] + ATAN_TURN[g];
        end else begin
          cx_q[g+1] <= cx_q[g] - ys;
          cy_q[g+1] <= cy_q[g] + xs;
          ca_q[g+1] <= ca_q[g] - ATAN_TURN[g];
        end
        cs_q[g+1] <= cs_q[g];
      end
    end
  end

  // ---------------- output stage ----------------
  side_t       cs_last;
  logic [31:0] ang_rnd;
  logic [15:0] head_base;

  assign cs_last   = cs_q[CORDIC_STAGES];
  assign ang_rnd   = ca_q[CORDIC_STAGES] + 32'h0000_8000;
  assign head_base = cs_last.zero ? 16'h0000 : ang_rnd[31:16];

  logic signed [15:0] mag_x_q, mag_y_q, mag_z_q;
  logic [15:0]        heading_q;
  logic               bus_error_q, saturated_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (cs_last.bus_err) begin
        mag_x_q     <= '0;
        mag_y_q     <= '0;
        mag_z_q     <= '0;
        heading_q   <= '0;
        bus_error_q <= 1'b1;
        saturated_q <= 1'b0;
      end else begin
        mag_x_q     <= cs_last.mx;
        mag_y_q     <= cs_last.my;
        mag_z_q     <= cs_last.mz;
        heading_q   <= head_base + decl_q;
        bus_error_q <= 1'b0;
        saturated_q <= cs_last.sat;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign mag_x_o     = mag_x_q;
  assign mag_y_o     = mag_y_q;
  assign mag_z_o     = mag_z_q;
  assign heading_o   = heading_q;
  assign bus_error_o = bus_error_q;
  assign saturated_o = saturated_q;

endmodule

/* test/magnetometer_calibrate_heading_tb.sv */
// Self-checking testbench for magnetometer_calibrate_heading: a directed table, then random
// samples under several calibrations, each reading checked against a local predictor.
// Depends on mcal_pkg and the block's RTL only.
module magnetometer_calibrate_heading_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcal_pkg::*;

  localparam int CORDIC_STAGES = 16;
  localparam int COEF_FRAC = 14;
  localparam int PIPE_LATENCY = CORDIC_STAGES + 5;
  localparam int STUCK_LIMIT = 4000;
  localparam int SEGMENT_ITEMS = 115;
  localparam logic [2:0] REG_NONE = 3'd7;

  // Arctangent of 2^-i as a fraction of a full turn, scaled by 2^32.
  localparam logic [31:0] ARC_STEP [CORDIC_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  typedef enum int {
    CAL_IDENTITY, CAL_EXTREME_HI, CAL_EXTREME_LO, CAL_WILD, CAL_REALISTIC
  } cal_kind_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               ok;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic [15:0]        heading;
    logic               bus_error;
    logic               saturated;
  } reading_t;

  typedef struct packed {
    sample_t  smp;
    logic     typed;
    reading_t want;
  } probe_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [47:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] raw_x_i = '0;
  logic signed [15:0] raw_y_i = '0;
  logic signed [15:0] raw_z_i = '0;
  logic               bus_ok_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] mag_x_o;
  logic signed [15:0] mag_y_o;
  logic signed [15:0] mag_z_o;
  logic [15:0]        heading_o;
  logic               bus_error_o;
  logic               saturated_o;

  // Calibration as the block should hold it.
  logic signed [15:0] cal_offset [3];
  logic [47:0]        cal_row [3];
  logic [15:0]        cal_decl;

  reading_t pending_readings [$];
  int       mismatches = 0;
  int       stuck_cycles = 0;
  int       tx_idle_pct = 8;
  int       rx_stall_pct = 73;

  // Typed rows hold at the reset calibration; bus errors hold under any calibration.
  probe_t probes [12] = '{
    '{'{16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b1, '{16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0}},
    '{'{16'h0000, 16'h0000, 16'h8000, 1'b1}, 1'b1, '{16'h0, 16'h0, 16'h8000, 16'h0, 1'b0, 1'b0}},
    '{'{16'h0000, 16'h0000, 16'h7FFF, 1'b1}, 1'b1, '{16'h0, 16'h0, 16'h7FFF, 16'h0, 1'b0, 1'b0}},
    '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0}, 1'b1, '{16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 1'b0}},
    '{'{16'h8000, 16'h8000, 16'h8000, 1'b0}, 1'b1, '{16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 1'b0}},
    '{'{16'h7FFF, 16'h0000, 16'h0000, 1'b1}, 1'b0, '0},
    '{'{16'h8000, 16'h0000, 16'h0000, 1'b1}, 1'b0, '0},
    '{'{16'h0000, 16'h7FFF, 16'h0000, 1'b1}, 1'b0, '0},
    '{'{16'h0000, 16'h8000, 16'h0000, 1'b1}, 1'b0, '0},
    '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1}, 1'b0, '0},
    '{'{16'h8000, 16'h8000, 16'h8000, 1'b1}, 1'b0, '0},
    '{'{16'hFFFF, 16'h0001, 16'h5555, 1'b1}, 1'b0, '0}
  };

  magnetometer_calibrate_heading i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_x_i     (raw_x_i),
    .raw_y_i     (raw_y_i),
    .raw_z_i     (raw_z_i),
    .bus_ok_i    (bus_ok_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mag_x_o     (mag_x_o),
    .mag_y_o     (mag_y_o),
    .mag_z_o     (mag_z_o),
    .heading_o   (heading_o),
    .bus_error_o (bus_error_o),
    .saturated_o (saturated_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cal_offset = '{16'sd0, 16'sd0, 16'sd0};
    cal_row = '{ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET};
    cal_decl = '0;
  end

  function automatic logic [31:0] cordic_bearing(input longint ex, input longint ny);
    longint vx, vy, sx, sy;
    logic [31:0] ang;
    vx = ex * 65536;
    vy = ny * 65536;
    ang = '0;
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      ang = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy >= 0) begin
        vx = vx + sy;
        vy = vy - sx;
        ang = ang + ARC_STEP[i];
      end else begin
        vx = vx - sy;
        vy = vy + sx;
        ang = ang - ARC_STEP[i];
      end
    end
    return ang;
  endfunction

  function automatic reading_t predict_reading(input sample_t s);
    reading_t r;
    longint dv [3];
    longint m [3];
    longint acc;
    logic [47:0] row;
    logic [31:0] ang;
    logic [15:0] bearing;
    logic clip;
    r = '0;
    if (!s.ok) begin
      r.bus_error = 1'b1;
      return r;
    end
    dv[0] = longint'(s.x) - longint'(cal_offset[0]);
    dv[1] = longint'(s.y) - longint'(cal_offset[1]);
    dv[2] = longint'(s.z) - longint'(cal_offset[2]);
    clip = 1'b0;
    for (int k = 0; k < 3; k++) begin
      row = cal_row[k];
      acc = longint'($signed(row[15:0])) * dv[0] + longint'($signed(row[31:16])) * dv[1]
          + longint'($signed(row[47:32])) * dv[2];
      acc = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (acc > 32767) begin
        acc = 32767;
        clip = 1'b1;
      end else if (acc < -32768) begin
        acc = -32768;
        clip = 1'b1;
      end
      m[k] = acc;
    end
    // With no horizontal field the heading is the declination alone.
    bearing = '0;
    if (m[0] != 0 || m[1] != 0) begin
      ang = cordic_bearing(m[0], m[1]) + 32'h8000;
      bearing = ang[31:16];
    end
    r.mag_x = 16'(m[0]);
    r.mag_y = 16'(m[1]);
    r.mag_z = 16'(m[2]);
    r.heading = bearing + cal_decl;
    r.saturated = clip;
    return r;
  endfunction

  function automatic logic [15:0] near_unity_coef();
    return 16'(16384 + int'($urandom_range(4096)) - 2048);
  endfunction

  function automatic logic [15:0] cross_coef();
    return 16'(int'($urandom_range(2048)) - 1024);
  endfunction

  function automatic sample_t next_sample();
    sample_t s;
    int pick;
    logic [15:0] corner [6];
    pick = $urandom_range(99);
    s.x = 16'($urandom);
    s.y = 16'($urandom);
    s.z = 16'($urandom);
    s.ok = 1'b1;
    if (pick < 4) begin
      s.ok = 1'b0;
    end else if (pick < 9) begin
      // Raw equals offset: a zero vector after correction.
      s.x = cal_offset[0];
      s.y = cal_offset[1];
      s.z = cal_offset[2];
    end else if (pick < 18) begin
      corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000};
      corner[5] = cal_offset[0];
      s.x = corner[$urandom_range(5)];
      corner[5] = cal_offset[1];
      s.y = corner[$urandom_range(5)];
      corner[5] = cal_offset[2];
      s.z = corner[$urandom_range(5)];
    end else if (pick < 45) begin
      s.x = cal_offset[0] + 16'(int'($urandom_range(4000)) - 2000);
      s.y = cal_offset[1] + 16'(int'($urandom_range(4000)) - 2000);
      s.z = cal_offset[2] + 16'(int'($urandom_range(4000)) - 2000);
    end
    return s;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [47:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_OFFSET_X: cal_offset[0] = data[15:0];
      REG_OFFSET_Y: cal_offset[1] = data[15:0];
      REG_OFFSET_Z: cal_offset[2] = data[15:0];
      REG_ROW_X:    cal_row[0] = data;
      REG_ROW_Y:    cal_row[1] = data;
      REG_ROW_Z:    cal_row[2] = data;
      REG_DECL:     cal_decl = data[15:0];
      default:      ;
    endcase
  endtask

  // Only called with the pipeline empty.
  task automatic load_calibration(input cal_kind_e kind);
    logic [47:0] junk;
    junk = {16'($urandom), 32'($urandom)};
    case (kind)
      CAL_IDENTITY: begin
        cfg_write(REG_OFFSET_X, 48'h0);
        cfg_write(REG_OFFSET_Y, 48'h0);
        cfg_write(REG_OFFSET_Z, 48'h0);
        cfg_write(REG_ROW_X, ROW_X_RESET);
        cfg_write(REG_ROW_Y, ROW_Y_RESET);
        cfg_write(REG_ROW_Z, ROW_Z_RESET);
        cfg_write(REG_DECL, 48'h8000);
      end
      CAL_EXTREME_HI: begin
        cfg_write(REG_OFFSET_X, 48'h8000);
        cfg_write(REG_OFFSET_Y, 48'h7FFF);
        cfg_write(REG_OFFSET_Z, 48'h8000);
        cfg_write(REG_ROW_X, {3{16'h7FFF}});
        cfg_write(REG_ROW_Y, {3{16'h7FFF}});
        cfg_write(REG_ROW_Z, {3{16'h7FFF}});
        cfg_write(REG_DECL, 48'h7FFF);
      end
      CAL_EXTREME_LO: begin
        cfg_write(REG_OFFSET_X, 48'h7FFF);
        cfg_write(REG_OFFSET_Y, 48'h8000);
        cfg_write(REG_OFFSET_Z, 48'h7FFF);
        cfg_write(REG_ROW_X, {3{16'h8000}});
        cfg_write(REG_ROW_Y, {3{16'h8000}});
        cfg_write(REG_ROW_Z, {3{16'h8000}});
        cfg_write(REG_DECL, 48'h8000);
      end
      CAL_WILD: begin
        // Upper data bits are don't-care for the 16-bit registers, so fill them.
        cfg_write(REG_OFFSET_X, {16'($urandom), 32'($urandom)});
        cfg_write(REG_OFFSET_Y, {16'($urandom), 32'($urandom)});
        cfg_write(REG_OFFSET_Z, {16'($urandom), 32'($urandom)});
        cfg_write(REG_ROW_X, {16'($urandom), 32'($urandom)});
        cfg_write(REG_ROW_Y, {16'($urandom), 32'($urandom)});
        cfg_write(REG_ROW_Z, {16'($urandom), 32'($urandom)});
        cfg_write(REG_DECL, {16'($urandom), 32'($urandom)});
      end
      default: begin
        cfg_write(REG_OFFSET_X, 48'(int'($urandom_range(4000)) - 2000));
        cfg_write(REG_OFFSET_Y, 48'(int'($urandom_range(4000)) - 2000));
        cfg_write(REG_OFFSET_Z, 48'(int'($urandom_range(4000)) - 2000));
        cfg_write(REG_ROW_X, {cross_coef(), cross_coef(), near_unity_coef()});
        cfg_write(REG_ROW_Y, {cross_coef(), near_unity_coef(), cross_coef()});
        cfg_write(REG_ROW_Z, {near_unity_coef(), cross_coef(), cross_coef()});
        cfg_write(REG_DECL, 48'($urandom));
      end
    endcase
    // A write beyond the last register must leave the calibration alone.
    cfg_write(REG_NONE, junk);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input sample_t s, input logic use_typed, input reading_t typed);
    reading_t want;
    want = use_typed ? typed : predict_reading(s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_x_i <= s.x;
    raw_y_i <= s.y;
    raw_z_i <= s.z;
    bus_ok_i <= s.ok;
    do @(posedge clk_i); while (in_stall_o);
    pending_readings.push_back(want);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  task automatic run_probes(input logic at_reset);
    for (int i = 0; i < $size(probes); i++) begin
      send_sample(probes[i].smp, probes[i].typed && (at_reset || !probes[i].smp.ok),
                  probes[i].want);
    end
  endtask

  task automatic match_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_readings.size() == 0) begin
        $error("reading arrived with none outstanding");
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        match_field("mag_x", want.mag_x, mag_x_o);
        match_field("mag_y", want.mag_y, mag_y_o);
        match_field("mag_z", want.mag_z, mag_z_o);
        match_field("heading", want.heading, heading_o);
        match_field("bus_error", want.bus_error, bus_error_o);
        match_field("saturated", want.saturated, saturated_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("magnetometer_calibrate_heading: mismatch");
      $finish;
    end
  end

  initial begin
    cal_kind_e plan [6];
    plan = '{CAL_IDENTITY, CAL_WILD, CAL_REALISTIC, CAL_EXTREME_LO, CAL_WILD, CAL_REALISTIC};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_probes(1'b1);
    settle();
    load_calibration(CAL_EXTREME_HI);
    run_probes(1'b0);

    for (int seg = 0; seg < 6; seg++) begin
      tx_idle_pct = (seg < 2) ? 8 : (seg < 4) ? 73 : 0;
      rx_stall_pct = (seg < 2) ? 73 : (seg < 4) ? 8 : 0;
      settle();
      load_calibration(plan[seg]);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        // Let the pipeline run dry halfway through each segment.
        if (n == SEGMENT_ITEMS / 2) settle();
        send_sample(next_sample(), 1'b0, '0);
      end
    end

    settle();
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("magnetometer_calibrate_heading: match");
    end else begin
      $display("magnetometer_calibrate_heading: mismatch");
    end
    $finish;
  end

endmodule
